// File: rtl/sdd_pkg.sv
package sdd_pkg;

  localparam int MAX_YEAR     = 9999;
  localparam int OFFSET_LIMIT = 4194303;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int OFFSET_W = 23;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REF_DAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_YEAR  = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Reciprocal of 25 scaled by 2^17; exact floor for every 14-bit year
  localparam int RECIP25_SHIFT = 17;
  localparam logic [12:0] RECIP25 = 13'd5243;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHK_T = 4'b0010,
    ST_CHK_R = 4'b0100,
    ST_WALK  = 4'b1000
  } state_t;

  // Gregorian leap rule: by 4, and not by 100 unless by 400.
  // By 100 is by 4 and 25; by 400 is by 16 and 25.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W+12:0] prod;
    logic [9:0]         q;
    logic [YEAR_W-1:0]  q25;
    logic               div4;
    logic               div16;
    logic               div25;
    prod  = {13'd0, y} * {{YEAR_W{1'b0}}, RECIP25};
    q     = prod[RECIP25_SHIFT +: 10];
    q25   = {4'd0, q} + {q, 4'd0} + {1'b0, q, 3'd0};
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (q25 == y);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB:                               len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default:                                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/signed_day_difference.sv
// Channel    Ports                                        Handshake
// ---------  -------------------------------------------  ------------------------------
// command    target_day, target_month, target_year       start high while busy is low
// result     day_offset, date_invalid                    done high for one cycle
// config     wr_index, wr_data                           wr_en high, no wait
//
// An item walks the earlier date forward one day a cycle through a single
// date incrementer until it meets the later date. busy stays high through
// both checks and the walk over the absolute day difference (up to 3652058
// across years 1..9999); done rises as busy falls. An invalid target holds
// busy for one cycle and an invalid reference for both checks, done again
// rising as busy falls. rst clears control and loads the reference date
// 1 January 2000. The receiver cannot stall: each result shows for one cycle.
module signed_day_difference (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sdd_pkg::DAY_W-1:0]     target_day,
  input  logic [sdd_pkg::MONTH_W-1:0]   target_month,
  input  logic [sdd_pkg::YEAR_W-1:0]    target_year,
  output logic                          done,
  output logic signed [sdd_pkg::OFFSET_W-1:0] day_offset,
  output logic                          date_invalid,
  input  logic                          wr_en,
  input  logic [sdd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sdd_pkg::CFG_W-1:0]     wr_data
);
  import sdd_pkg::*;

  // Reference date registers
  logic [DAY_W-1:0]   ref_day;
  logic [MONTH_W-1:0] ref_month;
  logic [YEAR_W-1:0]  ref_year;

  state_t state;
  state_t state_next;

  // Running date (the one that advances) and the date it must reach
  logic [DAY_W-1:0]    cur_d;
  logic [MONTH_W-1:0]  cur_m;
  logic [YEAR_W-1:0]   cur_y;
  logic [DAY_W-1:0]    end_d;
  logic [MONTH_W-1:0]  end_m;
  logic [YEAR_W-1:0]   end_y;
  logic [OFFSET_W-1:0] count;
  logic                neg;

  // Shared date unit: leap rule, month length, validity and next day
  logic               cur_leap;
  logic [DAY_W-1:0]   cur_len;
  logic               cur_ok;
  logic               month_end;
  logic [DAY_W-1:0]   step_d;
  logic [MONTH_W-1:0] step_m;
  logic [YEAR_W-1:0]  step_y;
  logic               cur_later;
  logic               at_end;

  always_comb begin
    cur_leap  = is_leap(cur_y);
    cur_len   = month_len(cur_m, cur_leap);
    cur_ok    = (cur_m >= MONTH_JAN) && (cur_m <= MONTH_DEC)
             && (cur_y != '0) && (32'(cur_y) <= MAX_YEAR)
             && (cur_d != '0) && (cur_d <= cur_len);
    month_end = (cur_d == cur_len);
    step_d    = month_end ? DAY_W'(1) : cur_d + DAY_W'(1);
    step_m    = cur_m;
    step_y    = cur_y;
    if (month_end) begin
      if (cur_m == MONTH_DEC) begin
        step_m = MONTH_JAN;
        step_y = cur_y + YEAR_W'(1);
      end else begin
        step_m = cur_m + MONTH_W'(1);
      end
    end
    // In the reference check cur holds the reference and end the target
    cur_later = {end_y, end_m, end_d} > {cur_y, cur_m, cur_d};
    at_end    = {end_y, end_m, end_d} == {cur_y, cur_m, cur_d};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CHK_T;
      ST_CHK_T: state_next = cur_ok ? ST_CHK_R : ST_IDLE;
      ST_CHK_R: state_next = cur_ok ? ST_WALK : ST_IDLE;
      ST_WALK:  if (at_end) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_day   <= DAY_W'(1);
      ref_month <= MONTH_JAN;
      ref_year  <= YEAR_W'(2000);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_REF_DAY:   ref_day   <= wr_data[DAY_W-1:0];
        REG_REF_MONTH: ref_month <= wr_data[MONTH_W-1:0];
        REG_REF_YEAR:  ref_year  <= wr_data[YEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == ST_CHK_T) && !cur_ok)
            || ((state == ST_CHK_R) && !cur_ok)
            || ((state == ST_WALK) && at_end);
    end
  end

  // Datapath: load, swap and walk
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // Hold the target in cur for its validity check
        cur_d <= target_day;
        cur_m <= target_month;
        cur_y <= target_year;
      end
      ST_CHK_T: begin
        // Park the target, bring in the reference
        end_d <= cur_d;
        end_m <= cur_m;
        end_y <= cur_y;
        cur_d <= ref_day;
        cur_m <= ref_month;
        cur_y <= ref_year;
        if (!cur_ok) begin
          day_offset   <= '0;
          date_invalid <= 1'b1;
        end
      end
      ST_CHK_R: begin
        count <= '0;
        neg   <= !cur_later;
        if (!cur_later) begin
          // Target is not later: swap so the target walks up to the reference
          cur_d <= end_d;
          cur_m <= end_m;
          cur_y <= end_y;
          end_d <= cur_d;
          end_m <= cur_m;
          end_y <= cur_y;
        end
        if (!cur_ok) begin
          day_offset   <= '0;
          date_invalid <= 1'b1;
        end
      end
      ST_WALK: begin
        if (at_end) begin
          day_offset   <= neg ? -$signed(count) : $signed(count);
          date_invalid <= 1'b0;
        end else begin
          cur_d <= step_d;
          cur_m <= step_m;
          cur_y <= step_y;
          // Saturate at the offset limit
          if (32'(count) != OFFSET_LIMIT) count <= count + OFFSET_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sdd_pkg::*;

  // The block decodes only three of the four index codes; the last one must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic                       invalid;
  } day_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [DAY_W-1:0]            target_day = '0;
  logic [MONTH_W-1:0]          target_month = '0;
  logic [YEAR_W-1:0]           target_year = '0;
  logic                        done;
  logic signed [OFFSET_W-1:0]  day_offset;
  logic                        date_invalid;
  logic                        wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        wr_index = '0;
  logic [CFG_W-1:0]            wr_data = '0;

  // Local copy of the reference date, kept in step with every register write.
  logic [DAY_W-1:0]            ref_d = 5'd1;
  logic [MONTH_W-1:0]          ref_m = MONTH_JAN;
  logic [YEAR_W-1:0]           ref_y = 14'd2000;

  day_result_t                 awaited_offsets[$];
  int                          fail_count = 0;
  bit                          idling_on = 1'b1;

  signed_day_difference u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .target_day   (target_day),
    .target_month (target_month),
    .target_year  (target_year),
    .done         (done),
    .day_offset   (day_offset),
    .date_invalid (date_invalid),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop: the slowest legal run is well under a tenth of this.
  initial begin
    #200_000_000;
    $display("signed_day_difference: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int m, input int y);
    int len;
    case (m) inside
      MONTH_FEB:                                  len = leap_year(y) ? 29 : 28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
      default:                                    len = 31;
    endcase
    return len;
  endfunction

  function automatic bit date_exists(input int d, input int m, input int y);
    if (m < MONTH_JAN || m > MONTH_DEC) return 1'b0;
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    return (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  // Days since a fixed origin: whole years first, then whole months, then the day.
  function automatic longint day_count(input int d, input int m, input int y);
    longint past;
    longint n;
    past = longint'(y) - 1;
    n = 365 * past + past / 4 - past / 100 + past / 400;
    for (int k = int'(MONTH_JAN); k < m; k++) n += longint'(days_in_month(k, y));
    return n + longint'(d);
  endfunction

  function automatic day_result_t predict_offset(input logic [DAY_W-1:0] d,
                                                 input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
    day_result_t r;
    longint      diff;
    if (!date_exists(int'(d), int'(m), int'(y))
        || !date_exists(int'(ref_d), int'(ref_m), int'(ref_y))) begin
      r.offset  = '0;
      r.invalid = 1'b1;
    end else begin
      diff = day_count(int'(d), int'(m), int'(y))
           - day_count(int'(ref_d), int'(ref_m), int'(ref_y));
      // Saturate, although the year range keeps the span inside the port
      if (diff > OFFSET_LIMIT) diff = longint'(OFFSET_LIMIT);
      if (diff < -OFFSET_LIMIT) diff = -longint'(OFFSET_LIMIT);
      r.offset  = diff[OFFSET_W-1:0];
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done cycle is compared with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    day_result_t want;
    if (!rst && done) begin
      if (awaited_offsets.size() == 0) begin
        fail_count++;
        $display("%0t: result with no item outstanding: offset %0d invalid %0b",
                 $time, day_offset, date_invalid);
      end else begin
        want = awaited_offsets.pop_front();
        if (day_offset !== want.offset) begin
          fail_count++;
          $display("%0t: day_offset expected %0d actual %0d",
                   $time, want.offset, day_offset);
        end
        if (date_invalid !== want.invalid) begin
          fail_count++;
          $display("%0t: date_invalid expected %0b actual %0b",
                   $time, want.invalid, date_invalid);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Leave start high on
  // return: the next item or a gap decides when it drops, so start never sees
  // two assignments in one step.
  task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0] y);
    start        <= 1'b1;
    target_day   <= d;
    target_month <= m;
    target_year  <= y;
    do @(posedge clk); while (busy);
    awaited_offsets.push_back(predict_offset(d, m, y));
  endtask

  // Drop start for a random stretch, mostly short with the odd long one, and
  // scramble the fields meanwhile so stale values cannot pass for a new item.
  task automatic idle_gap();
    int r;
    int n;
    if (!idling_on) return;
    r = $urandom_range(0, 99);
    n = (r < 45) ? 0 :
        (r < 85) ? $urandom_range(1, 3) :
        (r < 97) ? $urandom_range(4, 24) : $urandom_range(60, 400);
    if (n > 0) begin
      start        <= 1'b0;
      target_day   <= DAY_W'($urandom);
      target_month <= MONTH_W'($urandom);
      target_year  <= YEAR_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain: wait for every outstanding result, then let the clock run on so the
  // block is surely back in idle before its registers are touched.
  task automatic settle();
    start <= 1'b0;
    while (awaited_offsets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; wr_en stays high so that writes can run back to back.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_REF_DAY:   ref_d = data[DAY_W-1:0];
      REG_REF_MONTH: ref_m = data[MONTH_W-1:0];
      REG_REF_YEAR:  ref_y = data[YEAR_W-1:0];
      default:       ;
    endcase
  endtask

  task automatic set_reference(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] m,
                               input logic [CFG_W-1:0] y);
    settle();
    cfg_write(REG_REF_DAY, d);
    cfg_write(REG_REF_MONTH, m);
    cfg_write(REG_REF_YEAR, y);
    wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rely on the reset reference of 1 January 2000: no writes yet.
  task automatic test_reset_reference();
    send_date(5'd1, MONTH_JAN, 14'd2000);
    idle_gap();
    send_date(5'd29, MONTH_FEB, 14'd2000);
    idle_gap();
    send_date(5'd31, MONTH_DEC, 14'd1999);
    idle_gap();
  endtask

  // Targets that do not exist: each should flag and give a zero offset.
  task automatic test_invalid_targets();
    send_date(5'd0, MONTH_JAN, 14'd2000);
    idle_gap();
    send_date(5'd31, MONTH_APR, 14'd2000);
    idle_gap();
    send_date(5'd1, 4'd0, 14'd2000);
    idle_gap();
    send_date(5'd31, 4'd15, 14'd2000);
    idle_gap();
    send_date(5'd1, MONTH_JAN, 14'd0);
    idle_gap();
    send_date(5'd31, MONTH_DEC, {YEAR_W{1'b1}});
    idle_gap();
    send_date(5'd29, MONTH_FEB, 14'd2001);
    idle_gap();
  endtask

  // Leap rule: a century year that is not a leap, an ordinary leap and a
  // four-hundred year. Keep the reference a day or two away to keep walks short.
  task automatic test_leap_rule();
    int leap_years[3] = '{1900, 2004, 2400};
    foreach (leap_years[i]) begin
      set_reference(14'd1, CFG_W'(MONTH_SEP - 4'd6), CFG_W'(leap_years[i]));
      send_date(5'd28, MONTH_FEB, YEAR_W'(leap_years[i]));
      idle_gap();
      send_date(5'd29, MONTH_FEB, YEAR_W'(leap_years[i]));
      idle_gap();
    end
  endtask

  // First and last years of the range, reference and target alike.
  task automatic test_year_extremes();
    set_reference(14'd1, CFG_W'(MONTH_JAN), 14'd1);
    send_date(5'd1, MONTH_JAN, 14'd1);
    idle_gap();
    send_date(5'd31, MONTH_DEC, 14'd1);
    idle_gap();
    set_reference(14'd31, CFG_W'(MONTH_DEC), CFG_W'(MAX_YEAR));
    send_date(5'd31, MONTH_DEC, YEAR_W'(MAX_YEAR));
    idle_gap();
    send_date(5'd1, MONTH_JAN, YEAR_W'(MAX_YEAR));
    idle_gap();
  endtask

  // Two long walks, one backwards across a millennium and one forwards, so the
  // counter is exercised well beyond the short random spans.
  task automatic test_long_walk();
    set_reference(14'd1, CFG_W'(MONTH_JAN), 14'd2000);
    send_date(5'd1, 4'd3, 14'd1000);
    set_reference(14'd1, CFG_W'(MONTH_JAN), 14'd1);
    send_date(5'd1, MONTH_JAN, 14'd500);
  endtask

  // A reference that does not exist must flag even a perfectly good target.
  task automatic test_invalid_reference();
    set_reference(14'd31, CFG_W'(MONTH_APR), 14'd2000);
    send_date(5'd1, MONTH_JAN, 14'd2000);
    set_reference(14'd29, CFG_W'(MONTH_FEB), 14'd1900);
    send_date(5'd1, MONTH_JAN, 14'd1900);
    set_reference(14'd1, 14'd0, 14'd2000);
    send_date(5'd1, MONTH_JAN, 14'd2000);
    set_reference(14'd1, CFG_W'(MONTH_JAN), 14'd0);
    send_date(5'd1, MONTH_JAN, 14'd1);
    set_reference(14'd0, CFG_W'(MONTH_JAN), {CFG_W{1'b1}});
    send_date(5'd1, MONTH_JAN, YEAR_W'(MAX_YEAR));
  endtask

  // Write the spare index with all ones and the day register with junk above
  // its width; neither may disturb the reference, so the same date gives zero.
  task automatic test_unused_index();
    settle();
    cfg_write(REG_REF_DAY, 14'd15);
    cfg_write(REG_REF_MONTH, CFG_W'(MONTH_JUN));
    cfg_write(REG_REF_YEAR, 14'd1234);
    cfg_write(REG_UNUSED, {CFG_W{1'b1}});
    cfg_write(REG_REF_DAY, 14'h3FEF);
    wr_en <= 1'b0;
    send_date(5'd15, MONTH_JUN, 14'd1234);
    idle_gap();
  endtask

  // Random phases, each around a fresh reference. Most targets fall within a
  // couple of years of it, so walks stay short; the rest is noise that the
  // block must reject quickly. Phase two runs without any gaps.
  task automatic test_random_dates();
    int yr;
    int mo;
    int dy;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       yr = $urandom_range(1, 4);
        1:       yr = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
        default: yr = $urandom_range(1, MAX_YEAR);
      endcase
      mo = $urandom_range(MONTH_JAN, MONTH_DEC);
      dy = $urandom_range(1, days_in_month(mo, yr));
      set_reference(CFG_W'(dy), CFG_W'(mo), CFG_W'(yr));
      idling_on = (phase != 2);
      repeat (18) begin
        if ($urandom_range(0, 9) < 8) begin
          // Near the reference; years just outside the range wrap to invalid
          send_date(DAY_W'($urandom_range(1, 31)),
                    MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC)),
                    YEAR_W'(yr + int'($urandom_range(0, 4)) - 2));
        end else begin
          case ($urandom_range(0, 2))
            0:       send_date(DAY_W'($urandom_range(0, 31)),
                               MONTH_W'($urandom_range(0, 15)),
                               YEAR_W'($urandom_range(MAX_YEAR + 1, 2 ** YEAR_W - 1)));
            1:       send_date(5'd0, MONTH_W'($urandom_range(0, 15)), YEAR_W'(yr));
            default: send_date(DAY_W'($urandom_range(0, 31)),
                               MONTH_W'($urandom_range(MONTH_DEC + 1, 15)), YEAR_W'(yr));
          endcase
        end
        idle_gap();
      end
    end
    idling_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_reference();
    test_invalid_targets();
    test_leap_rule();
    test_year_extremes();
    test_long_walk();
    test_invalid_reference();
    test_unused_index();
    test_random_dates();

    // Drain the last results, then allow a little slack for any stray strobe
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("signed_day_difference: match");
    end else begin
      $display("signed_day_difference: mismatch");
    end
    $finish;
  end

endmodule
